// File: design/hsvrgb_pkg.sv
// shared types, widths and constants of the hsv to rgb converter
// no dependencies; referenced by scoped name from every module of the block
package hsvrgb_pkg;

    // field widths
    localparam int HUE_W = 15;
    localparam int CH_W  = 8;

    // one 60 degree sector spans 3840 codes of Q9.6 hue
    localparam int SECTOR_SPAN = 3840;
    localparam int MAX_SECTOR  = 8;
    localparam int SEC_W       = 4;
    localparam int REM_W       = 12;

    // common denominator 255 * 3840 and its rounding offset
    localparam int FRAC_DEN = 979200;
    localparam int HALF_DEN = FRAC_DEN / 2;
    localparam int DEN_W    = 20;
    localparam int PROD_W   = CH_W + DEN_W;

    // split the division: shift by 8, then divide by 3825 via reciprocal
    localparam int DIV_SHIFT   = 8;
    localparam int DIV_CONST   = FRAC_DEN >> DIV_SHIFT;
    localparam int Y_W         = PROD_W - DIV_SHIFT;
    localparam int RECIP_SHIFT = 32;
    localparam int RECIP_W     = 21;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((64'd1 << RECIP_SHIFT) / DIV_CONST);
    localparam int EST_W = Y_W + RECIP_W;
    localparam int Q0_W  = EST_W - RECIP_SHIFT;
    localparam int RES_W = Y_W + 1;

    // pipeline stages ahead of the output register
    localparam int NUM_STAGES = 5;

    // sector codes
    localparam logic [SEC_W-1:0] SEC_RED    = 4'd0;
    localparam logic [SEC_W-1:0] SEC_YELLOW = 4'd1;
    localparam logic [SEC_W-1:0] SEC_GREEN  = 4'd2;
    localparam logic [SEC_W-1:0] SEC_CYAN   = 4'd3;
    localparam logic [SEC_W-1:0] SEC_BLUE   = 4'd4;

    typedef struct packed {
        logic [HUE_W-1:0] hue_deg;
        logic [CH_W-1:0]  saturation;
        logic [CH_W-1:0]  brightness;
    } pixel_in_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } pixel_out_t;

    // result of the sector stage
    typedef struct packed {
        logic [SEC_W-1:0] sector;
        logic [REM_W-1:0] rem;
        logic [CH_W-1:0]  saturation;
        logic [CH_W-1:0]  brightness;
    } sect_t;

    // side band that travels beside the arithmetic
    typedef struct packed {
        logic [SEC_W-1:0] sector;
        logic [CH_W-1:0]  brightness;
        logic             grey;
    } side_t;

endpackage

// File: design/hsvrgb_sector.sv
// sector stage: finds the 60 degree sector of the hue and the remainder
// depends on hsvrgb_pkg
module hsvrgb_sector (
    input  logic                  aclk,
    input  logic                  en,
    input  hsvrgb_pkg::pixel_in_t pix,
    output hsvrgb_pkg::sect_t     sect
);

    logic [hsvrgb_pkg::SEC_W-1:0] sector_next;
    logic [hsvrgb_pkg::REM_W-1:0] rem_next;
    logic [hsvrgb_pkg::HUE_W-1:0] diff;
    hsvrgb_pkg::sect_t            sect_reg;

    // thresholds rise monotonically, so the last one passed wins
    always_comb begin
        sector_next = '0;
        rem_next    = pix.hue_deg[hsvrgb_pkg::REM_W-1:0];
        diff        = '0;
        for (int k = 1; k <= hsvrgb_pkg::MAX_SECTOR; k++) begin
            if (pix.hue_deg >= hsvrgb_pkg::HUE_W'(k * hsvrgb_pkg::SECTOR_SPAN)) begin
                sector_next = hsvrgb_pkg::SEC_W'(k);
                diff        = pix.hue_deg - hsvrgb_pkg::HUE_W'(k * hsvrgb_pkg::SECTOR_SPAN);
                rem_next    = diff[hsvrgb_pkg::REM_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sect_reg.sector     <= sector_next;
            sect_reg.rem        <= rem_next;
            sect_reg.saturation <= pix.saturation;
            sect_reg.brightness <= pix.brightness;
        end
    end

    assign sect = sect_reg;

endmodule

// File: design/hsvrgb_scale.sv
// two stage scaling: v * (979200 - s*k) + half, then drop the low 8 bits
// depends on hsvrgb_pkg
module hsvrgb_scale (
    input  logic                          aclk,
    input  logic                          en_mul,
    input  logic                          en_acc,
    input  logic [hsvrgb_pkg::CH_W-1:0]   sat,
    input  logic [hsvrgb_pkg::CH_W-1:0]   val,
    input  logic [hsvrgb_pkg::REM_W-1:0]  k,
    output logic [hsvrgb_pkg::Y_W-1:0]    y
);

    logic [hsvrgb_pkg::DEN_W-1:0]  prod_sk;
    logic [hsvrgb_pkg::DEN_W-1:0]  d_next;
    logic [hsvrgb_pkg::DEN_W-1:0]  d_reg;
    logic [hsvrgb_pkg::CH_W-1:0]   val_reg;
    logic [hsvrgb_pkg::PROD_W-1:0] n_sum;
    logic [hsvrgb_pkg::Y_W-1:0]    y_next;
    logic [hsvrgb_pkg::Y_W-1:0]    y_reg;

    // s*k never exceeds the denominator, so d stays non-negative
    assign prod_sk = hsvrgb_pkg::DEN_W'(sat) * hsvrgb_pkg::DEN_W'(k);
    assign d_next  = hsvrgb_pkg::DEN_W'(hsvrgb_pkg::FRAC_DEN) - prod_sk;

    always_ff @(posedge aclk) begin
        if (en_mul) begin
            d_reg   <= d_next;
            val_reg <= val;
        end
    end

    assign n_sum  = hsvrgb_pkg::PROD_W'(val_reg) * hsvrgb_pkg::PROD_W'(d_reg)
                  + hsvrgb_pkg::PROD_W'(hsvrgb_pkg::HALF_DEN);
    assign y_next = n_sum[hsvrgb_pkg::PROD_W-1:hsvrgb_pkg::DIV_SHIFT];

    always_ff @(posedge aclk) begin
        if (en_acc) begin
            y_reg <= y_next;
        end
    end

    assign y = y_reg;

endmodule

// File: design/hsvrgb_div.sv
// two stage divide by 3825: reciprocal estimate, then one correction step
// depends on hsvrgb_pkg
module hsvrgb_div (
    input  logic                        aclk,
    input  logic                        en_est,
    input  logic                        en_fix,
    input  logic [hsvrgb_pkg::Y_W-1:0]  y,
    output logic [hsvrgb_pkg::CH_W-1:0] q
);

    logic [hsvrgb_pkg::EST_W-1:0] est;
    logic [hsvrgb_pkg::Q0_W-1:0]  q0_next;
    logic [hsvrgb_pkg::Q0_W-1:0]  q0_reg;
    logic [hsvrgb_pkg::Y_W-1:0]   y_reg;
    logic [hsvrgb_pkg::RES_W-1:0] back;
    logic [hsvrgb_pkg::RES_W-1:0] resid;
    logic [hsvrgb_pkg::Q0_W-1:0]  q_fix;
    logic [hsvrgb_pkg::CH_W-1:0]  q_next;
    logic [hsvrgb_pkg::CH_W-1:0]  q_reg;

    // floored reciprocal: estimate is exact or one short
    assign est     = hsvrgb_pkg::EST_W'(y) * hsvrgb_pkg::EST_W'(hsvrgb_pkg::RECIP);
    assign q0_next = est[hsvrgb_pkg::EST_W-1:hsvrgb_pkg::RECIP_SHIFT];

    always_ff @(posedge aclk) begin
        if (en_est) begin
            q0_reg <= q0_next;
            y_reg  <= y;
        end
    end

    assign back   = hsvrgb_pkg::RES_W'(q0_reg) * hsvrgb_pkg::RES_W'(hsvrgb_pkg::DIV_CONST);
    assign resid  = hsvrgb_pkg::RES_W'(y_reg) - back;
    assign q_fix  = q0_reg
                  + hsvrgb_pkg::Q0_W'(resid >= hsvrgb_pkg::RES_W'(hsvrgb_pkg::DIV_CONST));
    assign q_next = q_fix[hsvrgb_pkg::CH_W-1:0];

    always_ff @(posedge aclk) begin
        if (en_fix) begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

// File: design/hsv_to_rgb_converter.sv
// top level of the hsv to rgb converter: stage control, side band, output mux
// depends on hsvrgb_pkg, hsvrgb_sector, hsvrgb_scale and hsvrgb_div
//
// Converts one HSV pixel (hue in degrees as unsigned Q9.6, saturation and
// brightness as k/255) to 8-bit RGB, each channel rounded half up. The block
// takes one request per clock while s_ready is high and holds six register
// stages: sector search, s*k product, v*(den - s*k) product, reciprocal
// estimate, quotient correction and the output register. The first of them
// loads at the edge that accepts the request, and the result moves through
// the others in that order before m_valid rises. The depth is set by the two
// multiplications on the brightness path and the two of the divide by the
// constant 979200, each given a stage of its own. Every stage has its own
// valid bit and holds only while the next stage is full and stalled, so
// bubbles close up and the input keeps being taken while a finished result
// waits in the output register. Zero saturation gives grey.
module hsv_to_rgb_converter (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  hsvrgb_pkg::pixel_in_t  s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output hsvrgb_pkg::pixel_out_t m_data
);

    // side band stages 1 to 4, one entry per stage
    typedef hsvrgb_pkg::side_t side_pipe_t [1:hsvrgb_pkg::NUM_STAGES-1];

    // per stage load enables; the last entry is the output register
    logic [hsvrgb_pkg::NUM_STAGES:0]   stage_en;
    logic [hsvrgb_pkg::NUM_STAGES-1:0] valid_reg;
    logic [hsvrgb_pkg::NUM_STAGES-1:0] valid_next;
    logic                         m_valid_reg;
    logic                         m_valid_next;

    hsvrgb_pkg::sect_t            sect;
    logic [hsvrgb_pkg::REM_W-1:0] k_t;
    side_pipe_t                   side_reg;
    hsvrgb_pkg::side_t            side_next;

    logic [hsvrgb_pkg::Y_W-1:0]   y_q;
    logic [hsvrgb_pkg::Y_W-1:0]   y_t;
    logic [hsvrgb_pkg::Y_W-1:0]   y_p;
    logic [hsvrgb_pkg::CH_W-1:0]  q_val;
    logic [hsvrgb_pkg::CH_W-1:0]  t_val;
    logic [hsvrgb_pkg::CH_W-1:0]  p_val;

    hsvrgb_pkg::pixel_out_t       out_next;
    hsvrgb_pkg::pixel_out_t       out_reg;

    // a stage loads when it is empty or its contents move on
    always_comb begin
        stage_en[hsvrgb_pkg::NUM_STAGES] = ~m_valid_reg | m_ready;
        for (int i = hsvrgb_pkg::NUM_STAGES - 1; i >= 0; i--) begin
            stage_en[i] = ~valid_reg[i] | stage_en[i+1];
        end
    end

    assign s_ready = stage_en[0];

    always_comb begin
        valid_next = valid_reg;
        if (stage_en[0]) begin
            valid_next[0] = s_valid;
        end
        for (int i = 1; i < hsvrgb_pkg::NUM_STAGES; i++) begin
            if (stage_en[i]) begin
                valid_next[i] = valid_reg[i-1];
            end
        end
        m_valid_next = stage_en[hsvrgb_pkg::NUM_STAGES] ?
                       valid_reg[hsvrgb_pkg::NUM_STAGES-1] : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // stage 0: sector and remainder
    hsvrgb_sector u_sector (
        .aclk (aclk),
        .en   (stage_en[0]),
        .pix  (s_data),
        .sect (sect)
    );

    // stages 1 and 2: three scaled numerators, for q, t and p
    assign k_t = hsvrgb_pkg::REM_W'(hsvrgb_pkg::SECTOR_SPAN) - sect.rem;

    hsvrgb_scale u_scale_q (
        .aclk   (aclk),
        .en_mul (stage_en[1]),
        .en_acc (stage_en[2]),
        .sat    (sect.saturation),
        .val    (sect.brightness),
        .k      (sect.rem),
        .y      (y_q)
    );

    hsvrgb_scale u_scale_t (
        .aclk   (aclk),
        .en_mul (stage_en[1]),
        .en_acc (stage_en[2]),
        .sat    (sect.saturation),
        .val    (sect.brightness),
        .k      (k_t),
        .y      (y_t)
    );

    // a full sector span turns the q form into v*(255-s)/255
    hsvrgb_scale u_scale_p (
        .aclk   (aclk),
        .en_mul (stage_en[1]),
        .en_acc (stage_en[2]),
        .sat    (sect.saturation),
        .val    (sect.brightness),
        .k      (hsvrgb_pkg::REM_W'(hsvrgb_pkg::SECTOR_SPAN)),
        .y      (y_p)
    );

    // stages 3 and 4: divide by 3825
    hsvrgb_div u_div_q (
        .aclk   (aclk),
        .en_est (stage_en[3]),
        .en_fix (stage_en[4]),
        .y      (y_q),
        .q      (q_val)
    );

    hsvrgb_div u_div_t (
        .aclk   (aclk),
        .en_est (stage_en[3]),
        .en_fix (stage_en[4]),
        .y      (y_t),
        .q      (t_val)
    );

    hsvrgb_div u_div_p (
        .aclk   (aclk),
        .en_est (stage_en[3]),
        .en_fix (stage_en[4]),
        .y      (y_p),
        .q      (p_val)
    );

    // sector, brightness and grey flag follow the arithmetic
    always_comb begin
        side_next.sector     = sect.sector;
        side_next.brightness = sect.brightness;
        side_next.grey       = (sect.saturation == '0);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            side_reg[1] <= side_next;
        end
        for (int i = 2; i < hsvrgb_pkg::NUM_STAGES; i++) begin
            if (stage_en[i]) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // output: six-way permutation by sector, grey overrides
    always_comb begin
        out_next.red   = side_reg[hsvrgb_pkg::NUM_STAGES-1].brightness;
        out_next.green = side_reg[hsvrgb_pkg::NUM_STAGES-1].brightness;
        out_next.blue  = side_reg[hsvrgb_pkg::NUM_STAGES-1].brightness;
        if (!side_reg[hsvrgb_pkg::NUM_STAGES-1].grey) begin
            unique case (side_reg[hsvrgb_pkg::NUM_STAGES-1].sector)
                hsvrgb_pkg::SEC_RED: begin
                    out_next.green = t_val;
                    out_next.blue  = p_val;
                end
                hsvrgb_pkg::SEC_YELLOW: begin
                    out_next.red  = q_val;
                    out_next.blue = p_val;
                end
                hsvrgb_pkg::SEC_GREEN: begin
                    out_next.red  = p_val;
                    out_next.blue = t_val;
                end
                hsvrgb_pkg::SEC_CYAN: begin
                    out_next.red   = p_val;
                    out_next.green = q_val;
                end
                hsvrgb_pkg::SEC_BLUE: begin
                    out_next.red   = t_val;
                    out_next.green = p_val;
                end
                // magenta sector and hue at or past 360 degrees
                default: begin
                    out_next.green = p_val;
                    out_next.blue  = q_val;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[hsvrgb_pkg::NUM_STAGES]) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule
